// File: hdl/hvng_pkg.sv
// Package with the transaction types, operation codes and alphabet lookup of the n-gram encoder.
`timescale 1ns / 1ps

package hvng_pkg;

  // Number of item vectors: 'a' to 'z' and space.
  localparam int unsigned ITEM_COUNT = 27;
  localparam int unsigned ENTRY_W = $clog2(ITEM_COUNT);
  localparam logic [ENTRY_W-1:0] SPACE_ENTRY = ENTRY_W'(26);

  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam int unsigned SUM_W = 32;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CHAR  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  symbol;
    logic [4:0]  entry_index;
    logic [63:0] entry_vector;
    logic [5:0]  element_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               symbol_matched;
  } out_item_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] entry;
  } lookup_t;

  // Maps a text byte to its item entry; hit is low for bytes outside the alphabet.
  function automatic lookup_t symbol_lookup(input logic [7:0] sym);
    lookup_t res;
    logic [7:0] offset;
    offset = sym - CHAR_LOWER_A;
    res.hit = 1'b0;
    res.entry = offset[ENTRY_W-1:0];
    if (sym >= CHAR_LOWER_A && sym <= CHAR_LOWER_Z) begin
      res.hit = 1'b1;
    end else if (sym == CHAR_SPACE) begin
      res.hit = 1'b1;
      res.entry = SPACE_ENTRY;
    end
    return res;
  endfunction

endpackage

// File: hdl/hypervector_ngram_encoder_unit.sv
// Top level of the hyperdimensional n-gram encoder: item memory, window, sums and output skid.
`timescale 1ns / 1ps

// Channel   Signals                                  Direction  Payload
// -------   --------------------------------------   ---------  -----------------------
// item      item_valid, item_ready, item             in         hvng_pkg::in_item_t
// result    result_valid, result_ready, result       out        hvng_pkg::out_item_t
//
// Every accepted transaction produces exactly one registered result transaction.
// A new item can be accepted in every cycle unless the skid register is full; the window
// shift, the row product and the DIM parallel saturating adders feed the sum registers.
// Synchronous reset clears the window, the sums, the character count and the output
// stages; the item memory holds no defined value until it is loaded.
// When the result side stalls, one more result is parked in a skid register, and the
// item side is held off only while that skid register is full.

module hypervector_ngram_encoder_unit #(
  parameter int unsigned NGRAM = 4,
  parameter int unsigned DIM = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  hvng_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output hvng_pkg::out_item_t result
);

  import hvng_pkg::*;

  localparam int unsigned CNT_W = $clog2(NGRAM + 1);
  localparam logic [CNT_W-1:0] NGRAM_C = CNT_W'(NGRAM);
  localparam int unsigned IDX_W = $clog2(DIM);
  localparam logic [6:0] DIM_C = 7'(DIM);

  // Item memory: one bipolar vector per letter and space, bit set means -1.
  logic [DIM-1:0] item_mem [ITEM_COUNT];

  // Ternary window: a sign bit and a nonzero bit per element and row.
  logic [DIM-1:0] win_sign [NGRAM];
  logic [DIM-1:0] win_nz [NGRAM];
  logic [DIM-1:0] win_sign_next [NGRAM];
  logic [DIM-1:0] win_nz_next [NGRAM];

  logic signed [SUM_W-1:0] sums [DIM];
  logic signed [SUM_W-1:0] sums_next [DIM];

  logic [CNT_W-1:0] chars_seen;
  logic [CNT_W-1:0] chars_seen_next;

  logic      skid_valid;
  out_item_t skid;

  logic      accept;
  lookup_t   lookup;
  out_item_t res;
  logic      elem_in_range;

  logic [DIM-1:0] shift_sign [NGRAM];
  logic [DIM-1:0] shift_nz [NGRAM];
  logic [DIM-1:0] prod_nz;
  logic [DIM-1:0] prod_sign;

  assign item_ready = !skid_valid;
  assign accept = item_valid && item_ready;
  assign lookup = symbol_lookup(item.symbol);
  assign elem_in_range = {1'b0, item.element_index} < DIM_C;

  // Window after one character: rows rotate by one element and move down a row, the
  // old last row wraps to row 0, and a symbol of the alphabet overwrites row 0.
  always_comb begin
    for (int r = 1; r < NGRAM; r++) begin
      shift_sign[r] = {win_sign[r-1][DIM-2:0], win_sign[r-1][DIM-1]};
      shift_nz[r] = {win_nz[r-1][DIM-2:0], win_nz[r-1][DIM-1]};
    end
    shift_sign[0] = {win_sign[NGRAM-1][DIM-2:0], win_sign[NGRAM-1][DIM-1]};
    shift_nz[0] = {win_nz[NGRAM-1][DIM-2:0], win_nz[NGRAM-1][DIM-1]};
    if (lookup.hit) begin
      shift_sign[0] = item_mem[lookup.entry];
      shift_nz[0] = '1;
    end
  end

  // Element-wise product of the ternary rows: zero if any row is zero, sign is the parity.
  always_comb begin
    prod_nz = '1;
    prod_sign = '0;
    for (int r = 0; r < NGRAM; r++) begin
      prod_nz = prod_nz & shift_nz[r];
      prod_sign = prod_sign ^ shift_sign[r];
    end
  end

  // Next state of the window, the sums and the character count.
  always_comb begin
    win_sign_next = win_sign;
    win_nz_next = win_nz;
    sums_next = sums;
    chars_seen_next = chars_seen;
    unique case (item.operation)
      OP_CLEAR: begin
        for (int r = 0; r < NGRAM; r++) begin
          win_sign_next[r] = '0;
          win_nz_next[r] = '0;
        end
        for (int j = 0; j < DIM; j++) begin
          sums_next[j] = '0;
        end
        chars_seen_next = '0;
      end
      OP_CHAR: begin
        win_sign_next = shift_sign;
        win_nz_next = shift_nz;
        if (chars_seen != NGRAM_C) begin
          chars_seen_next = chars_seen + CNT_W'(1);
        end
        if (chars_seen_next == NGRAM_C) begin
          for (int j = 0; j < DIM; j++) begin
            if (prod_nz[j]) begin
              if (prod_sign[j]) begin
                sums_next[j] = (sums[j] == SUM_MIN) ? sums[j] : sums[j] - SUM_W'(1);
              end else begin
                sums_next[j] = (sums[j] == SUM_MAX) ? sums[j] : sums[j] + SUM_W'(1);
              end
            end
          end
        end
      end
      OP_LOAD, OP_READ: begin
      end
      default: begin
      end
    endcase
  end

  // Result of the current item; a read sees the sums as they stood before it.
  always_comb begin
    res.read_value = '0;
    res.symbol_matched = 1'b0;
    if (item.operation == OP_READ && elem_in_range) begin
      res.read_value = sums[item.element_index[IDX_W-1:0]];
    end
    if (item.operation == OP_CHAR) begin
      res.symbol_matched = lookup.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.operation == OP_LOAD && {27'b0, item.entry_index} < ITEM_COUNT) begin
      item_mem[item.entry_index] <= item.entry_vector[DIM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NGRAM; r++) begin
        win_sign[r] <= '0;
        win_nz[r] <= '0;
      end
      for (int j = 0; j < DIM; j++) begin
        sums[j] <= '0;
      end
      chars_seen <= '0;
    end else if (accept) begin
      win_sign <= win_sign_next;
      win_nz <= win_nz_next;
      sums <= sums_next;
      chars_seen <= chars_seen_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= skid_valid ? skid : res;
    end else if (accept) begin
      skid <= res;
    end
  end

  // The skid register only fills behind a held result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid register holds a result while the output register is empty");

  // The character count never runs past the window length.
  assert property (@(posedge clk) disable iff (rst) chars_seen <= NGRAM_C)
    else $error("character count above the n-gram length");

  // A clear transaction leaves an empty window behind.
  assert property (@(posedge clk) disable iff (rst)
    accept && item.operation == OP_CLEAR |=> chars_seen == '0 && win_nz[0] == '0)
    else $error("window not empty after a clear transaction");

  // Every accepted transaction leaves a result in one of the two output stages.
  assert property (@(posedge clk) disable iff (rst) accept |=> result_valid)
    else $error("accepted transaction produced no result");

endmodule
